// File: src/bcsv_pkg.sv
// ----------------------------------------------------------------------------
// bcsv_pkg: shared types and constants of the per-block crc32 store/verify unit
// Holds the operation and status codes, the field widths and the byte-wise
// reflected crc-32 update.
// ----------------------------------------------------------------------------
package bcsv_pkg;

  // field widths fixed by the stream format
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned BLOCK_W    = 10;
  localparam int unsigned CRC_W      = 32;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 48;

  // reflected crc-32 polynomial and preset / final xor
  localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFFFFFF;

  // operation carried in tuser
  typedef enum logic [FUNC_W-1:0] {
    FN_STORE  = 2'd0,
    FN_VERIFY = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_NOP    = 2'd3
  } func_e;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    ST_STORED   = 3'd0,
    ST_MATCH    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_NONE     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  // request to the valid-mark clearing sequencer
  typedef struct packed {
    logic              start;
    logic [SLOT_W-1:0] slot;
  } sweep_req_t;

  // fold one byte into a reflected crc, eight shift steps unrolled
  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: src/bcsv_ram.sv
// ----------------------------------------------------------------------------
// bcsv_ram: generic simple dual-port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bcsv_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bcsv_sweep.sv
// ----------------------------------------------------------------------------
// bcsv_sweep: valid-mark clearing sequencer
// Walks the whole table once after reset, and the block range of one slot on
// a clear, giving one address per cycle to be written with a cleared mark.
// ----------------------------------------------------------------------------
module bcsv_sweep #(
  parameter int unsigned CHUNK_SLOTS      = 8,
  parameter int unsigned BLOCKS_PER_CHUNK = 1024,
  localparam int unsigned DEPTH  = CHUNK_SLOTS * BLOCKS_PER_CHUNK,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bcsv_pkg::sweep_req_t  req_i,
  output logic                  busy_o,
  output logic [ADDR_W-1:0]     addr_o
);

  import bcsv_pkg::*;

  logic              busy_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] last_q;
  logic [ADDR_W-1:0] first_addr;
  logic [ADDR_W-1:0] last_addr;

  // address range of one slot
  assign first_addr = ADDR_W'(32'(req_i.slot) * BLOCKS_PER_CHUNK);
  assign last_addr  = ADDR_W'(32'(req_i.slot) * BLOCKS_PER_CHUNK + BLOCKS_PER_CHUNK - 1);

  // sweep counter, starts busy over the whole table out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      addr_q <= '0;
      last_q <= ADDR_W'(DEPTH - 1);
    end else if (busy_q) begin
      if (addr_q == last_q) begin
        busy_q <= 1'b0;
      end else begin
        addr_q <= addr_q + ADDR_W'(1);
      end
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      addr_q <= first_addr;
      last_q <= last_addr;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = addr_q;

endmodule

// File: src/block_crc32_store_verify.sv
// ----------------------------------------------------------------------------
// block_crc32_store_verify: per-block crc-32 store and verify
// Folds tagged data bytes into a reflected crc-32 and stores or checks the
// crc of each finished block against a per-slot, per-block table.
// ----------------------------------------------------------------------------
// The unit takes one byte per cycle unless a sweep or output back-pressure
// holds it off, and gives a result for each transfer that ends a block or
// clears a slot through its input register, table read stage and output
// register. The running crc is one unrolled 8-bit update per advancing byte and
// the table is a single ram with one write and one registered read per cycle.
// A clear of a slot holds off input while its valid marks are written back, and
// after reset the whole table is swept before input is taken.
module block_crc32_store_verify #(
  parameter int unsigned CHUNK_SLOTS      = 8,
  parameter int unsigned BLOCKS_PER_CHUNK = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // data_byte [7:0], chunk_slot [10:8], block_num [20:11], zero pad
  input  logic [bcsv_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // func [1:0]
  input  logic [bcsv_pkg::FUNC_W-1:0]        s_axis_tuser_i,
  // block_end
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // crc_value [31:0], out_slot [34:32], out_block [44:35], zero pad
  output logic [bcsv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // status [2:0]
  output logic [bcsv_pkg::STATUS_W-1:0]      m_axis_tuser_o
);

  import bcsv_pkg::*;

  localparam int unsigned DEPTH  = CHUNK_SLOTS * BLOCKS_PER_CHUNK;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RAM_W  = CRC_W + 1;

  typedef struct packed {
    logic [CRC_W-1:0]   crc;
    logic [SLOT_W-1:0]  slot;
    logic [BLOCK_W-1:0] block;
    status_e            status;
    logic               verify;
  } s2_t;

  // input register
  logic               s1_valid_q;
  func_e              s1_func_q;
  logic [BYTE_W-1:0]  s1_byte_q;
  logic [SLOT_W-1:0]  s1_slot_q;
  logic [BLOCK_W-1:0] s1_block_q;
  logic               s1_end_q;
  logic [CRC_W-1:0]   running_crc_q;

  // table read stage and output register
  logic               s2_valid_q;
  s2_t                s2_q;
  s2_t                s2_d;
  logic               out_valid_q;
  logic [CRC_W-1:0]   out_crc_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic [BLOCK_W-1:0] out_block_q;
  status_e            out_status_q;
  status_e            out_status_d;

  logic               s1_data;
  logic               s1_slot_ok;
  logic               s1_in_range;
  logic               s1_clear;
  logic               s1_report;
  logic [CRC_W-1:0]   fold_crc;
  logic [CRC_W-1:0]   final_crc;
  logic [ADDR_W-1:0]  s1_idx;
  logic               out_free;
  logic               s2_free;
  logic               s1_adv;
  logic               s1_free;
  logic               in_xfer;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [RAM_W-1:0]   ram_rdata;
  logic               store_we;
  sweep_req_t         sweep_req;
  logic               sweep_busy;
  logic [ADDR_W-1:0]  sweep_addr;

  // decode of the held item
  assign s1_data     = (s1_func_q == FN_STORE) || (s1_func_q == FN_VERIFY);
  assign s1_slot_ok  = 32'(s1_slot_q) < CHUNK_SLOTS;
  assign s1_in_range = s1_slot_ok && (32'(s1_block_q) < BLOCKS_PER_CHUNK);
  assign s1_clear    = (s1_func_q == FN_CLEAR) && s1_slot_ok;
  assign s1_report   = (s1_data && s1_end_q) || s1_clear;
  assign s1_idx      = ADDR_W'(32'(s1_slot_q) * BLOCKS_PER_CHUNK + 32'(s1_block_q));

  // crc update
  assign fold_crc  = crc_fold(running_crc_q, s1_byte_q);
  assign final_crc = fold_crc ^ CRC_ALL_ONES;

  // flow control, an item waits in the input register during a sweep
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s2_free         = !s2_valid_q || out_free;
  assign s1_adv          = s1_valid_q && !sweep_busy && (!s1_report || s2_free);
  assign s1_free         = !s1_valid_q || s1_adv;
  assign s_axis_tready_o = s1_free && !sweep_busy;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_func_q  <= func_e'(s_axis_tuser_i);
      s1_byte_q  <= s_axis_tdata_i[7:0];
      s1_slot_q  <= s_axis_tdata_i[10:8];
      s1_block_q <= s_axis_tdata_i[20:11];
      s1_end_q   <= s_axis_tlast_i;
    end
  end

  // running crc, back to preset at block end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_crc_q <= CRC_ALL_ONES;
    end else if (s1_adv && s1_data) begin
      running_crc_q <= s1_end_q ? CRC_ALL_ONES : fold_crc;
    end
  end

  // table access, the sweep owns the write port while busy
  assign store_we  = s1_adv && s1_data && s1_end_q && s1_in_range && (s1_func_q == FN_STORE);
  assign ram_we    = sweep_busy || store_we;
  assign ram_waddr = sweep_busy ? sweep_addr : s1_idx;
  assign ram_wdata = sweep_busy ? '0 : {1'b1, final_crc};
  assign ram_re    = s1_adv && s1_data && s1_end_q && s1_in_range &&
                     (s1_func_q == FN_VERIFY);

  assign sweep_req.start = s1_adv && s1_clear;
  assign sweep_req.slot  = s1_slot_q;

  bcsv_sweep #(
    .CHUNK_SLOTS      (CHUNK_SLOTS),
    .BLOCKS_PER_CHUNK (BLOCKS_PER_CHUNK)
  ) u_sweep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sweep_req),
    .busy_o (sweep_busy),
    .addr_o (sweep_addr)
  );

  bcsv_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (s1_idx),
    .rdata_o (ram_rdata)
  );

  // preliminary result of the held item
  always_comb begin
    s2_d.crc    = final_crc;
    s2_d.slot   = s1_slot_q;
    s2_d.block  = s1_block_q;
    s2_d.status = ST_NONE;
    s2_d.verify = 1'b0;
    if (s1_clear) begin
      s2_d.crc    = '0;
      s2_d.block  = '0;
      s2_d.status = ST_CLEARED;
    end else if (s1_in_range) begin
      if (s1_func_q == FN_STORE) begin
        s2_d.status = ST_STORED;
      end else begin
        s2_d.verify = 1'b1;
      end
    end
  end

  // table read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_adv && s1_report;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_report) begin
      s2_q <= s2_d;
    end
  end

  // compare against the stored entry
  always_comb begin
    out_status_d = s2_q.status;
    if (s2_q.verify) begin
      if (!ram_rdata[CRC_W]) begin
        out_status_d = ST_NONE;
      end else if (ram_rdata[CRC_W-1:0] == s2_q.crc) begin
        out_status_d = ST_MATCH;
      end else begin
        out_status_d = ST_MISMATCH;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s2_valid_q) begin
      out_crc_q    <= s2_q.crc;
      out_slot_q   <= s2_q.slot;
      out_block_q  <= s2_q.block;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W - CRC_W - SLOT_W - BLOCK_W){1'b0}},
                            out_block_q, out_slot_q, out_crc_q};
  assign m_axis_tuser_o  = out_status_q;

  // a store write never meets a verify read in the same cycle
  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("table write and read in the same cycle");

  // a clear always starts its sweep
  a_clear_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_req.start |=> sweep_busy)
    else $error("clear did not start the sweep");

  // a waiting verify keeps its read data
  a_rdata_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_free) |=>
      (s2_valid_q && $stable(s2_q) && (!s2_q.verify || $stable(ram_rdata))))
    else $error("read stage changed while stalled");

  // no item moves past the input register during a sweep
  a_hold_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_busy |-> !(ram_re || store_we || sweep_req.start))
    else $error("item advanced during sweep");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the per-block crc-32 store/verify unit
// Drives tagged bytes, clears and ignored ops on the input stream and follows
// every transfer with a bit-true predictor of the running crc, the checksum
// table and its valid marks. Each output transfer is compared field by field
// with the oldest pending result. A short directed table comes first, then
// random block traffic under three sender/receiver stall settings.
// ----------------------------------------------------------------------------
module tb_top;
  import bcsv_pkg::*;

  localparam int unsigned SLOTS          = 8;
  localparam int unsigned BLOCKS         = 1024;
  localparam int unsigned TABLE_SIZE     = SLOTS * BLOCKS;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned ITEMS_TOTAL    = 1200;
  localparam int unsigned SAVED_MAX      = 48;
  // the reset sweep and a clear hold off input for long, so leave plenty of room
  localparam int unsigned WATCHDOG_LIMIT = 40000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned MAX_REPORTS    = 10;

  // one input transfer
  typedef struct packed {
    func_e              op;
    logic [BYTE_W-1:0]  data;
    logic [SLOT_W-1:0]  slot;
    logic [BLOCK_W-1:0] blk;
    logic               last;
  } byte_xfer_t;

  // one block report
  typedef struct packed {
    logic [CRC_W-1:0]   crc;
    logic [SLOT_W-1:0]  slot;
    logic [BLOCK_W-1:0] blk;
    status_e            status;
  } block_report_t;

  // fixed expectation carried along with a directed transfer
  typedef struct packed {
    logic          fixed;
    block_report_t want;
  } fixed_note_t;

  typedef struct packed {
    byte_xfer_t  xfer;
    fixed_note_t note;
  } directed_row_t;

  // block content kept around for later verify passes
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [BLOCK_W-1:0] blk;
    logic [3:0]         len;
    logic [63:0]        bytes;
  } saved_blk_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [FUNC_W-1:0]      s_tuser  = '0;
  logic                   s_tlast  = 1'b0;
  logic                   m_tready = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]    m_axis_tuser_o;

  // predictor state
  logic [CRC_W-1:0] model_crc;
  logic [CRC_W-1:0] stored_crc [TABLE_SIZE];
  logic             stored_ok  [TABLE_SIZE];

  block_report_t pending_reports[$];
  fixed_note_t   fixed_notes[$];
  directed_row_t directed_rows[$];
  saved_blk_t    saved_blocks[$];

  int unsigned s_idle_pct = 0;
  int unsigned r_idle_pct = 0;
  int unsigned sent_items = 0;
  int unsigned fail_count = 0;
  int unsigned in_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned status_seen [5] = '{default: 0};

  block_crc32_store_verify #(
    .CHUNK_SLOTS      (SLOTS),
    .BLOCKS_PER_CHUNK (BLOCKS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // reflected crc-32, one data bit per step, lsb first
  function automatic logic [CRC_W-1:0] crc_byte_update(input logic [CRC_W-1:0] crc,
                                                       input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    logic             fb;
    c = crc;
    for (int k = 0; k < BYTE_W; k++) begin
      fb = c[0] ^ b[k];
      c  = {1'b0, c[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  // advance the predictor by one transfer, returns 1 when a report is due
  function automatic logic predict_block_report(input byte_xfer_t x,
                                                output block_report_t r);
    logic [CRC_W-1:0] fin;
    int unsigned      idx;
    r = '0;
    if (x.op == FN_CLEAR) begin
      for (int i = 0; i < BLOCKS; i++) stored_ok[x.slot * BLOCKS + i] = 1'b0;
      r.slot   = x.slot;
      r.status = ST_CLEARED;
      return 1'b1;
    end
    if (x.op == FN_NOP) return 1'b0;
    model_crc = crc_byte_update(model_crc, x.data);
    if (!x.last) return 1'b0;
    fin       = model_crc ^ CRC_ALL_ONES;
    model_crc = CRC_ALL_ONES;
    idx       = x.slot * BLOCKS + x.blk;
    r.crc     = fin;
    r.slot    = x.slot;
    r.blk     = x.blk;
    if (x.op == FN_STORE) begin
      stored_crc[idx] = fin;
      stored_ok[idx]  = 1'b1;
      r.status        = ST_STORED;
    end else if (!stored_ok[idx]) begin
      r.status = ST_NONE;
    end else if (stored_crc[idx] == fin) begin
      r.status = ST_MATCH;
    end else begin
      r.status = ST_MISMATCH;
    end
    return 1'b1;
  endfunction

  function automatic byte_xfer_t random_xfer();
    byte_xfer_t x;
    x.op   = func_e'($urandom_range(3));
    x.data = BYTE_W'($urandom);
    x.slot = SLOT_W'($urandom_range(SLOTS - 1));
    x.blk  = BLOCK_W'($urandom_range(BLOCKS - 1));
    x.last = 1'($urandom_range(1));
    return x;
  endfunction

  // directed row, expected report filled in when fixed is set
  task automatic add_row(input func_e op, input logic [7:0] data, input logic [2:0] slot,
                         input logic [9:0] blk, input logic last, input logic fixed,
                         input logic [31:0] crc, input status_e st);
    directed_row_t row;
    row.xfer             = '{op: op, data: data, slot: slot, blk: blk, last: last};
    row.note.fixed       = fixed;
    row.note.want.crc    = crc;
    row.note.want.slot   = slot;
    row.note.want.blk    = (op == FN_CLEAR) ? '0 : blk;
    row.note.want.status = st;
    directed_rows.push_back(row);
  endtask

  // drive one transfer and hold it until it is taken
  task automatic send_byte(input byte_xfer_t x, input fixed_note_t note);
    while ($urandom_range(99) < s_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    fixed_notes.push_back(note);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - BYTE_W - SLOT_W - BLOCK_W){1'b0}}, x.blk, x.slot, x.data};
    s_tuser  <= x.op;
    s_tlast  <= x.last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sent_items++;
  endtask

  // one block of bytes; mix scrambles ops and tags of all but the last byte,
  // broken drops an extra random transfer (an ignored op or a stray byte that may end the block early) into the middle
  task automatic send_block(input saved_blk_t sb, input func_e fin, input logic mix,
                            input logic broken);
    byte_xfer_t x;
    logic       at_end;
    for (int i = 0; i < sb.len; i++) begin
      if (broken && i == sb.len / 2) begin
        x = random_xfer();
        if (x.op == FN_CLEAR) x.op = FN_NOP;
        send_byte(x, '0);
      end
      at_end = (i == sb.len - 1);
      x.data = sb.bytes[8*i +: 8];
      x.last = at_end;
      if (at_end || !mix) begin
        x.op   = fin;
        x.slot = sb.slot;
        x.blk  = sb.blk;
      end else begin
        x.op   = func_e'($urandom_range(1));
        x.slot = SLOT_W'($urandom_range(SLOTS - 1));
        x.blk  = BLOCK_W'($urandom_range(BLOCKS - 1));
      end
      send_byte(x, '0);
    end
  endtask

  // mostly store/verify round trips over a small set of blocks, plus noise
  task automatic random_traffic(input int unsigned target);
    int unsigned pick;
    saved_blk_t  sb;
    byte_xfer_t  x;
    while (sent_items < target) begin
      pick = $urandom_range(999);
      if (pick < 280 || saved_blocks.size() == 0) begin
        sb.slot  = SLOT_W'($urandom_range(SLOTS - 1));
        sb.blk   = $urandom_range(1) ? BLOCK_W'($urandom_range(15))
                                     : BLOCK_W'($urandom_range(BLOCKS - 1));
        sb.len   = 4'($urandom_range(8, 1));
        sb.bytes = {$urandom, $urandom};
        send_block(sb, FN_STORE, $urandom_range(3) == 0, 1'b0);
        saved_blocks.push_back(sb);
        if (saved_blocks.size() > SAVED_MAX) void'(saved_blocks.pop_front());
      end else if (pick < 800) begin
        sb = saved_blocks[$urandom_range(saved_blocks.size() - 1)];
        if (pick >= 580 && pick < 740) begin
          sb.bytes[$urandom_range(sb.len * 8 - 1)] ^= 1'b1;
        end else if (pick >= 740) begin
          sb.slot = SLOT_W'($urandom_range(SLOTS - 1));
          sb.blk  = BLOCK_W'($urandom_range(BLOCKS - 1));
        end
        send_block(sb, FN_VERIFY, $urandom_range(3) == 0, pick % 10 == 0);
      end else if (pick < 950) begin
        send_byte(random_xfer(), '0);
      end else if (pick < 990) begin
        sb.slot  = SLOT_W'($urandom_range(SLOTS - 1));
        sb.blk   = BLOCK_W'($urandom_range(15));
        sb.len   = 4'($urandom_range(8, 2));
        sb.bytes = {$urandom, $urandom};
        send_block(sb, func_e'($urandom_range(1)), 1'b1, 1'b1);
      end else begin
        x      = random_xfer();
        x.op   = FN_CLEAR;
        send_byte(x, '0);
      end
    end
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= r_idle_pct);
  end

  // prediction on input transfers, checking on output transfers, watchdog
  always @(posedge clk_i) begin : monitor
    byte_xfer_t    x;
    block_report_t r;
    block_report_t got;
    fixed_note_t   note;
    logic          s_acc;
    logic          m_acc;
    s_acc = rst_ni && s_tvalid && s_axis_tready_o;
    m_acc = rst_ni && m_axis_tvalid_o && m_tready;
    if (s_acc) begin
      in_count++;
      x.data = s_tdata[BYTE_W-1:0];
      x.slot = s_tdata[BYTE_W +: SLOT_W];
      x.blk  = s_tdata[BYTE_W + SLOT_W +: BLOCK_W];
      x.op   = func_e'(s_tuser);
      x.last = s_tlast;
      note   = fixed_notes.pop_front();
      if (predict_block_report(x, r)) begin
        pending_reports.push_back(note.fixed ? note.want : r);
      end
    end
    if (m_acc) begin
      got.crc    = m_axis_tdata_o[CRC_W-1:0];
      got.slot   = m_axis_tdata_o[CRC_W +: SLOT_W];
      got.blk    = m_axis_tdata_o[CRC_W + SLOT_W +: BLOCK_W];
      got.status = status_e'(m_axis_tuser_o);
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("[%0t] unexpected result: crc %08h slot %0d block %0d status %0d",
                   $time, got.crc, got.slot, got.blk, got.status);
        end
      end else begin
        r = pending_reports.pop_front();
        if (got.status <= ST_CLEARED) status_seen[got.status]++;
        if (got.crc != r.crc || got.slot != r.slot || got.blk != r.blk ||
            got.status != r.status) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: exp crc %08h slot %0d block %0d status %0d",
                     $time, r.crc, r.slot, r.blk, r.status);
            $display("[%0t]           got crc %08h slot %0d block %0d status %0d",
                     $time, got.crc, got.slot, got.blk, got.status);
          end
        end
      end
    end
    // watchdog on cycles without any transfer
    if (s_acc || m_acc) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    model_crc = CRC_ALL_ONES;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      stored_crc[i] = '0;
      stored_ok[i]  = 1'b0;
    end

    // extremes, every op, error codes
    add_row(FN_STORE,  8'h00, 3'd0, 10'd0,    1'b1, 1'b1, 32'hD202EF8D, ST_STORED);
    add_row(FN_STORE,  8'hFF, 3'd7, 10'd1023, 1'b1, 1'b1, 32'hFF000000, ST_STORED);
    add_row(FN_VERIFY, 8'hFF, 3'd7, 10'd1023, 1'b1, 1'b1, 32'hFF000000, ST_MATCH);
    add_row(FN_VERIFY, 8'h00, 3'd7, 10'd1023, 1'b1, 1'b1, 32'hD202EF8D, ST_MISMATCH);
    add_row(FN_VERIFY, 8'h00, 3'd3, 10'd5,    1'b1, 1'b1, 32'hD202EF8D, ST_NONE);
    // ignored op with end mark set: no result
    add_row(FN_NOP,    8'hA5, 3'd2, 10'd2,    1'b1, 1'b0, '0, ST_STORED);
    // check string "123456789" with mixed modes, an ignored op and a clear inside
    add_row(FN_VERIFY, 8'h31, 3'd1, 10'd512,  1'b0, 1'b0, '0, ST_STORED);
    add_row(FN_VERIFY, 8'h32, 3'd1, 10'd512,  1'b0, 1'b0, '0, ST_STORED);
    add_row(FN_VERIFY, 8'h33, 3'd1, 10'd512,  1'b0, 1'b0, '0, ST_STORED);
    add_row(FN_VERIFY, 8'h34, 3'd1, 10'd512,  1'b0, 1'b0, '0, ST_STORED);
    add_row(FN_NOP,    8'h00, 3'd1, 10'd512,  1'b0, 1'b0, '0, ST_STORED);
    add_row(FN_STORE,  8'h35, 3'd1, 10'd512,  1'b0, 1'b0, '0, ST_STORED);
    add_row(FN_STORE,  8'h36, 3'd1, 10'd512,  1'b0, 1'b0, '0, ST_STORED);
    add_row(FN_CLEAR,  8'h00, 3'd7, 10'd0,    1'b0, 1'b1, 32'h0, ST_CLEARED);
    add_row(FN_STORE,  8'h37, 3'd1, 10'd512,  1'b0, 1'b0, '0, ST_STORED);
    add_row(FN_STORE,  8'h38, 3'd1, 10'd512,  1'b0, 1'b0, '0, ST_STORED);
    add_row(FN_STORE,  8'h39, 3'd1, 10'd512,  1'b1, 1'b1, 32'hCBF43926, ST_STORED);
    // cleared slot reports nothing stored, other slots keep their marks
    add_row(FN_VERIFY, 8'hFF, 3'd7, 10'd1023, 1'b1, 1'b1, 32'hFF000000, ST_NONE);
    add_row(FN_VERIFY, 8'h00, 3'd0, 10'd0,    1'b1, 1'b1, 32'hD202EF8D, ST_MATCH);
    add_row(FN_VERIFY, 8'h39, 3'd1, 10'd512,  1'b1, 1'b0, '0, ST_STORED);
    // clear ignores data, block and end mark
    add_row(FN_CLEAR,  8'hFF, 3'd0, 10'd1023, 1'b1, 1'b1, 32'h0, ST_CLEARED);
    add_row(FN_VERIFY, 8'h00, 3'd0, 10'd0,    1'b1, 1'b1, 32'hD202EF8D, ST_NONE);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles lightly, receiver heavily
    s_idle_pct = 12;
    r_idle_pct = 65;
    foreach (directed_rows[i]) send_byte(directed_rows[i].xfer, directed_rows[i].note);
    random_traffic(ITEMS_TOTAL / 3);

    // the other way round
    s_idle_pct = 65;
    r_idle_pct = 12;
    random_traffic(2 * ITEMS_TOTAL / 3);

    // full rate both sides
    s_idle_pct = 0;
    r_idle_pct = 0;
    random_traffic(ITEMS_TOTAL);
    s_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_reports.size() != 0) fail_count++;
    $display("covered %0d input transfers (%0d directed) under three stall settings",
             in_count, directed_rows.size());
    $display("results: stored %0d, match %0d, mismatch %0d, none %0d, cleared %0d",
             status_seen[ST_STORED], status_seen[ST_MATCH], status_seen[ST_MISMATCH],
             status_seen[ST_NONE], status_seen[ST_CLEARED]);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
